[sv/mbab_pkg.sv]
// Shared types and constants for the minute bar / ATR builder.
// Used by every module of the block but mbab_ram; no dependencies of its own.
`timescale 1ns / 1ps

package mbab_pkg;

    // Default sizing
    localparam int MAX_WINDOW_DEF = 64;
    localparam int PRICE_BITS_DEF = 32;

    // Fixed field widths
    localparam int MINUTE_W = 11;
    localparam int VOLUME_W = 32;
    localparam int AVG_W    = 32;
    localparam int RCOUNT_W = 6;
    localparam int CFG_W    = 7;

    localparam logic [CFG_W-1:0]    WINDOW_RESET = 7'd20;
    localparam logic [VOLUME_W-1:0] VOLUME_MAX   = 32'hFFFF_FFFF;
    localparam logic [AVG_W-1:0]    AVG_MAX      = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DIV,
        ST_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // take the request on the input side
        logic walk;       // walk the history
        logic div_start;  // seed the divider
        logic load;       // load the output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic closes;     // the offered request closes the running bar
        logic walk_done;  // all history terms summed
        logic div_done;   // quotient ready
    } status_t;

endpackage

[sv/mbab_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mbab_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/mbab_ctrl.sv]
// Controller of the minute bar / ATR builder: sequences accept, history
// walk, division and output load. Depends on mbab_pkg.
`timescale 1ns / 1ps

module mbab_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  mbab_pkg::status_t status,
    output mbab_pkg::cmd_t    cmd
);

    mbab_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign s_axis_tready = (state_reg == mbab_pkg::ST_IDLE);

    // State and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbab_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        unique case (state_reg)
            mbab_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (status.closes)
                    begin
                        state_next = mbab_pkg::ST_WALK;
                    end
                end
            end
            mbab_pkg::ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.walk_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = mbab_pkg::ST_DIV;
                end
            end
            mbab_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = mbab_pkg::ST_OUT;
                end
            end
            mbab_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = mbab_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mbab_pkg::ST_IDLE;
            end
        endcase
    end

    // Never overwrite a result that is still waiting
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || m_axis_tready))
        else $error("output loaded while occupied");

    // A closing request starts the history walk
    a_close_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && status.closes) |=>
            (state_reg == mbab_pkg::ST_WALK))
        else $error("closing request did not start walk");

    // Division starts only after the sum is complete
    a_div_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> status.walk_done)
        else $error("divider started before walk finished");

    // Output becomes valid right after a load
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> m_axis_tvalid)
        else $error("load did not raise output valid");

endmodule

[sv/mbab_dp.sv]
// Datapath of the minute bar / ATR builder: running bar, history RAM,
// true range accumulator, restoring divider and output register.
// Depends on mbab_pkg and mbab_ram.
`timescale 1ns / 1ps

module mbab_dp #(
    parameter int MAX_WINDOW = mbab_pkg::MAX_WINDOW_DEF,
    parameter int PRICE_BITS = mbab_pkg::PRICE_BITS_DEF,
    parameter int IN_W       = 80,
    parameter int OUT_W      = 216
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [IN_W-1:0]            s_axis_tdata,
    output logic [OUT_W-1:0]           m_axis_tdata,
    input  logic                       cfg_valid,
    input  logic [mbab_pkg::CFG_W-1:0] cfg_data,
    input  mbab_pkg::cmd_t             cmd,
    output mbab_pkg::status_t          status
);

    localparam int IDX_W   = $clog2(MAX_WINDOW);
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = PRICE_BITS + CNT_W;
    localparam int DCNT_W  = $clog2(SUM_W + 1);
    localparam int WCMP_W  = (CNT_W > mbab_pkg::CFG_W) ? CNT_W : mbab_pkg::CFG_W;
    localparam int EXT_W   = (SUM_W > mbab_pkg::AVG_W) ? SUM_W : mbab_pkg::AVG_W;
    localparam int MW      = mbab_pkg::MINUTE_W;
    localparam int VW      = mbab_pkg::VOLUME_W;
    localparam int PAD_W   = OUT_W - (MW + 4 * PRICE_BITS + VW + mbab_pkg::AVG_W
                                      + mbab_pkg::RCOUNT_W);

    function automatic logic [PRICE_BITS-1:0] abs_diff(
        input logic signed [PRICE_BITS-1:0] a,
        input logic signed [PRICE_BITS-1:0] b
    );
        logic signed [PRICE_BITS:0] d;
        d = {a[PRICE_BITS-1], a} - {b[PRICE_BITS-1], b};
        if (d[PRICE_BITS])
        begin
            d = -d;
        end
        return d[PRICE_BITS-1:0];
    endfunction

    // Input fields
    logic [MW-1:0]                in_minute;
    logic signed [PRICE_BITS-1:0] in_price;
    logic [VW-1:0]                in_volume;

    assign in_minute = s_axis_tdata[MW-1:0];
    assign in_price  = s_axis_tdata[MW+PRICE_BITS-1:MW];
    assign in_volume = s_axis_tdata[MW+PRICE_BITS+VW-1:MW+PRICE_BITS];

    // Window register
    logic [mbab_pkg::CFG_W-1:0] window_reg;
    logic [WCMP_W-1:0]          window_ext;
    logic [CNT_W-1:0]           window_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= mbab_pkg::WINDOW_RESET;
        end
        else if (cfg_valid)
        begin
            window_reg <= cfg_data;
        end
    end

    // Clamp the window to 1..MAX_WINDOW
    always_comb
    begin
        window_ext = WCMP_W'(window_reg);
        if (window_ext == '0)
        begin
            window_eff = CNT_W'(1);
        end
        else if (window_ext > WCMP_W'(MAX_WINDOW))
        begin
            window_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            window_eff = CNT_W'(window_ext);
        end
    end

    // Running bar state
    logic                         started_reg;
    logic [MW-1:0]                open_minute_reg;
    logic signed [PRICE_BITS-1:0] run_open_reg, run_high_reg, run_low_reg, run_close_reg;
    logic [VW-1:0]                run_volume_reg;
    logic [VW:0]                  vol_sum;
    logic [VW-1:0]                vol_next;
    logic                         same_bar;

    assign same_bar      = started_reg && (in_minute == open_minute_reg);
    assign status.closes = started_reg && (in_minute != open_minute_reg);
    assign vol_sum       = {1'b0, run_volume_reg} + {1'b0, in_volume};
    assign vol_next      = vol_sum[VW] ? mbab_pkg::VOLUME_MAX : vol_sum[VW-1:0];

    // History bookkeeping
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] fill_reg, fill_next, cnt_reg, cnt_next;
    logic [CNT_W:0]   fill_inc;
    logic [CNT_W:0]   oldest_wide;
    logic [IDX_W-1:0] oldest;

    always_comb
    begin
        head_next = (head_reg == IDX_W'(MAX_WINDOW - 1)) ? '0 : head_reg + 1'b1;
        fill_inc  = {1'b0, fill_reg} + 1'b1;
        fill_next = (fill_inc > {1'b0, window_eff}) ? window_eff : fill_inc[CNT_W-1:0];
        cnt_next  = (fill_next >= CNT_W'(2)) ? fill_next - 1'b1 : '0;
        if ((CNT_W + 1)'(head_next) >= {1'b0, fill_next})
        begin
            oldest_wide = (CNT_W + 1)'(head_next) - {1'b0, fill_next};
        end
        else
        begin
            oldest_wide = (CNT_W + 1)'(head_next) + (CNT_W + 1)'(MAX_WINDOW)
                          - {1'b0, fill_next};
        end
        oldest = oldest_wide[IDX_W-1:0];
    end

    // Closed bar held for output
    logic [MW-1:0]                c_minute_reg;
    logic signed [PRICE_BITS-1:0] c_open_reg, c_high_reg, c_low_reg, c_close_reg;
    logic [VW-1:0]                c_volume_reg;

    // Walk state
    logic [IDX_W-1:0]             rd_addr_reg;
    logic [CNT_W-1:0]             rd_left_reg;
    logic                         rdv_reg, first_reg, s1_vld_reg;
    logic                         rd_en;
    logic [3*PRICE_BITS-1:0]      rd_data;
    logic signed [PRICE_BITS-1:0] rd_high, rd_low, rd_close, prev_close_reg;
    logic [PRICE_BITS-1:0]        d_hl_reg, d_hc_reg, d_lc_reg, tr_max;
    logic [SUM_W-1:0]             sum_reg;

    assign rd_en   = cmd.walk && (rd_left_reg != '0);
    assign rd_high  = rd_data[PRICE_BITS-1:0];
    assign rd_low   = rd_data[2*PRICE_BITS-1:PRICE_BITS];
    assign rd_close = rd_data[3*PRICE_BITS-1:2*PRICE_BITS];
    assign status.walk_done = (rd_left_reg == '0) && !rdv_reg && !s1_vld_reg;

    mbab_ram #(
        .WIDTH (3 * PRICE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_hist (
        .clk   (clk),
        .we    (cmd.accept && status.closes),
        .waddr (head_reg),
        .wdata ({run_close_reg, run_low_reg, run_high_reg}),
        .re    (rd_en),
        .raddr (rd_addr_reg),
        .rdata (rd_data)
    );

    // Pick the largest of the three distances
    always_comb
    begin
        tr_max = d_hl_reg;
        if (d_hc_reg > tr_max)
        begin
            tr_max = d_hc_reg;
        end
        if (d_lc_reg > tr_max)
        begin
            tr_max = d_lc_reg;
        end
    end

    // Divider
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic [CNT_W:0]    rem_sh;
    logic [EXT_W-1:0]  quo_ext;
    logic [mbab_pkg::AVG_W-1:0] avg;

    assign status.div_done = (dcnt_reg == '0);
    assign rem_sh  = {rem_reg, quo_reg[SUM_W-1]};
    assign quo_ext = EXT_W'(quo_reg);

    // Saturate the quotient; no terms gives zero
    always_comb
    begin
        if (cnt_reg == '0)
        begin
            avg = '0;
        end
        else if (quo_ext > EXT_W'(mbab_pkg::AVG_MAX))
        begin
            avg = mbab_pkg::AVG_MAX;
        end
        else
        begin
            avg = quo_ext[mbab_pkg::AVG_W-1:0];
        end
    end

    // Control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            head_reg    <= '0;
            fill_reg    <= '0;
            rd_left_reg <= '0;
            rdv_reg     <= 1'b0;
            s1_vld_reg  <= 1'b0;
            first_reg   <= 1'b0;
            dcnt_reg    <= '0;
        end
        else
        begin
            rdv_reg    <= rd_en;
            s1_vld_reg <= rdv_reg && !first_reg;
            if (rdv_reg)
            begin
                first_reg <= 1'b0;
            end
            if (rd_en)
            begin
                rd_left_reg <= rd_left_reg - 1'b1;
            end
            if (cmd.accept)
            begin
                started_reg <= 1'b1;
                if (status.closes)
                begin
                    head_reg    <= head_next;
                    fill_reg    <= fill_next;
                    rd_left_reg <= fill_next;
                    first_reg   <= 1'b1;
                end
            end
            if (cmd.div_start)
            begin
                dcnt_reg <= DCNT_W'(SUM_W);
            end
            else if (dcnt_reg != '0)
            begin
                dcnt_reg <= dcnt_reg - 1'b1;
            end
        end
    end

    // Running bar payload; the walk and divider payload follow in the next block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_minute_reg <= '0;
            run_open_reg    <= '0;
            run_high_reg    <= '0;
            run_low_reg     <= '0;
            run_close_reg   <= '0;
            run_volume_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            if (same_bar)
            begin
                if (in_price > run_high_reg)
                begin
                    run_high_reg <= in_price;
                end
                if (in_price < run_low_reg)
                begin
                    run_low_reg <= in_price;
                end
                run_close_reg  <= in_price;
                run_volume_reg <= vol_next;
            end
            else
            begin
                open_minute_reg <= in_minute;
                run_open_reg    <= in_price;
                run_high_reg    <= in_price;
                run_low_reg     <= in_price;
                run_close_reg   <= in_price;
                run_volume_reg  <= in_volume;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // Capture the closed bar and seed the walk
        if (cmd.accept && status.closes)
        begin
            c_minute_reg <= open_minute_reg;
            c_open_reg   <= run_open_reg;
            c_high_reg   <= run_high_reg;
            c_low_reg    <= run_low_reg;
            c_close_reg  <= run_close_reg;
            c_volume_reg <= run_volume_reg;
            cnt_reg      <= cnt_next;
            rd_addr_reg  <= oldest;
            sum_reg      <= '0;
        end
        else
        begin
            // Advance the read address
            if (rd_en)
            begin
                rd_addr_reg <= (rd_addr_reg == IDX_W'(MAX_WINDOW - 1)) ?
                               '0 : rd_addr_reg + 1'b1;
            end
            // Stage one: the bar's high-low range and its distances from the previous close
            if (rdv_reg)
            begin
                d_hl_reg       <= abs_diff(rd_high, rd_low);
                d_hc_reg       <= abs_diff(rd_high, prev_close_reg);
                d_lc_reg       <= abs_diff(rd_low, prev_close_reg);
                prev_close_reg <= rd_close;
            end
            // Stage two: accumulate true range
            if (s1_vld_reg)
            begin
                sum_reg <= sum_reg + SUM_W'(tr_max);
            end
        end
        // Restoring division, one quotient bit per cycle
        if (cmd.div_start)
        begin
            quo_reg <= sum_reg;
            rem_reg <= '0;
        end
        else if (dcnt_reg != '0)
        begin
            if (rem_sh >= {1'b0, cnt_reg})
            begin
                rem_reg <= CNT_W'(rem_sh - {1'b0, cnt_reg});
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[CNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        // Load the output register
        if (cmd.load)
        begin
            m_axis_tdata <= {{PAD_W{1'b0}},
                             mbab_pkg::RCOUNT_W'(cnt_reg),
                             avg,
                             c_volume_reg,
                             c_close_reg,
                             c_low_reg,
                             c_high_reg,
                             c_open_reg,
                             c_minute_reg};
        end
    end

endmodule

[sv/minute_bar_atr_builder.sv]
// Minute bar builder with average true range: top level.
// A closing tick's bar comes out after a walk of the history (one history read per held bar)
// and a division (one divider bit per cycle). Input stalls from a closing tick until its bar
// is loaded. Ticks that do not close a bar do not stall the input. Reset (rst_n, async, low)
// empties the bar and history and sets the window to 20; no clearing pass is needed.
`timescale 1ns / 1ps

module minute_bar_atr_builder #(
    parameter int MAX_WINDOW = mbab_pkg::MAX_WINDOW_DEF,
    parameter int PRICE_BITS = mbab_pkg::PRICE_BITS_DEF,
    parameter int IN_W  = ((mbab_pkg::MINUTE_W + PRICE_BITS + mbab_pkg::VOLUME_W + 7) / 8) * 8,
    parameter int OUT_W = ((mbab_pkg::MINUTE_W + 4 * PRICE_BITS + mbab_pkg::VOLUME_W
                           + mbab_pkg::AVG_W + mbab_pkg::RCOUNT_W + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // minute_of_day, price, tick_volume
    input  logic [IN_W-1:0]            s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // bar_minute, bar_open, bar_high, bar_low, bar_close, bar_volume,
    // average_range, range_count
    output logic [OUT_W-1:0]           m_axis_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [mbab_pkg::CFG_W-1:0] cfg_data
);

    mbab_pkg::cmd_t    cmd;
    mbab_pkg::status_t status;

    assign cfg_ready = 1'b1;

    mbab_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    mbab_dp #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS),
        .IN_W       (IN_W),
        .OUT_W      (OUT_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

[tb/minute_bar_atr_builder_test.sv]
// Self-checking bench for the minute bar / ATR builder: ticks go in, closed bars come out.
// A local bar and history model predicts every closed bar; depends on mbab_pkg and the RTL.
`timescale 1ns / 1ps

module minute_bar_atr_builder_test;

    localparam int IN_W  = 80;
    localparam int OUT_W = 216;
    localparam int HIST  = 64;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct packed {
        logic [31:0] volume;
        logic [31:0] price;
        logic [10:0] minute;
    } tick_t;

    typedef struct packed {
        logic [5:0]  count;
        logic [31:0] avg;
        logic [31:0] volume;
        logic [31:0] close_px;
        logic [31:0] low_px;
        logic [31:0] high_px;
        logic [31:0] open_px;
        logic [10:0] minute;
    } bar_t;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [IN_W-1:0]            s_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_W-1:0]           m_axis_tdata;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [mbab_pkg::CFG_W-1:0] cfg_data;

    minute_bar_atr_builder u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Predictor state
    logic [6:0]         win_len;
    bit                 bar_open_flag;
    logic [10:0]        run_minute;
    longint             cur_open, cur_high, cur_low, cur_close;
    longint unsigned    cur_volume;
    longint             hist_high[HIST], hist_low[HIST], hist_close[HIST];
    int                 hist_fill, hist_head;

    tick_t  pending_ticks[$];
    bar_t   expected_bars[$];
    int     ticks_sent, bars_seen, mismatches, config_writes;
    bit     in_taken;

    function automatic longint unsigned abs_gap(longint a, longint b);
        return (a >= b) ? longint'(a - b) : longint'(b - a);
    endfunction

    // Fold one accepted tick into the predicted bar; queue a bar when it closes
    function automatic void fold_tick(tick_t t);
        longint px;
        longint unsigned sum, tr, cnt, avg;
        int w, cur, prv;
        bar_t b;
        px = longint'($signed(t.price));
        if (bar_open_flag && t.minute == run_minute)
        begin
            if (px > cur_high) cur_high = px;
            if (px < cur_low) cur_low = px;
            cur_close = px;
            cur_volume += t.volume;
            if (cur_volume > 64'hFFFF_FFFF) cur_volume = 64'hFFFF_FFFF;
            return;
        end
        if (bar_open_flag)
        begin
            w = (win_len < 1) ? 1 : (win_len > HIST) ? HIST : int'(win_len);
            hist_high[hist_head] = cur_high;
            hist_low[hist_head] = cur_low;
            hist_close[hist_head] = cur_close;
            hist_head = (hist_head + 1) % HIST;
            hist_fill++;
            if (hist_fill > w) hist_fill = w;
            cnt = (hist_fill >= 2) ? hist_fill - 1 : 0;
            sum = 0;
            for (int i = 1; i < hist_fill; i++)
            begin
                cur = (hist_head + HIST - hist_fill + i) % HIST;
                prv = (cur + HIST - 1) % HIST;
                tr = abs_gap(hist_high[cur], hist_low[cur]);
                if (abs_gap(hist_high[cur], hist_close[prv]) > tr)
                    tr = abs_gap(hist_high[cur], hist_close[prv]);
                if (abs_gap(hist_low[cur], hist_close[prv]) > tr)
                    tr = abs_gap(hist_low[cur], hist_close[prv]);
                sum += tr;
            end
            avg = (cnt > 0) ? sum / cnt : 0;
            if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
            b.minute = run_minute;
            b.open_px = cur_open[31:0];
            b.high_px = cur_high[31:0];
            b.low_px = cur_low[31:0];
            b.close_px = cur_close[31:0];
            b.volume = cur_volume[31:0];
            b.avg = avg[31:0];
            b.count = cnt[5:0];
            expected_bars.insert(expected_bars.size(), b);
        end
        bar_open_flag = 1'b1;
        run_minute = t.minute;
        cur_open = px;
        cur_high = px;
        cur_low = px;
        cur_close = px;
        cur_volume = t.volume;
    endfunction

    // Driver: present queued ticks with random gaps
    int    tx_gap;
    tick_t tx_tick;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            tx_gap = 0;
            in_taken = 1'b0;
        end
        else if (s_axis_tvalid && !in_taken)
        begin
            // hold the request
        end
        else
        begin
            in_taken = 1'b0;
            if (tx_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                tx_gap--;
            end
            else if (pending_ticks.size() > 0)
            begin
                tx_tick = pending_ticks[0];
                pending_ticks.delete(0);
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= IN_W'(tx_tick);
                tx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Track what the driver offered so acceptance updates the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            fold_tick(tick_t'(s_axis_tdata[74:0]));
            in_taken = 1'b1;
            ticks_sent++;
        end
    end

    // Sink backpressure: random stall lengths, some stretches always ready
    int rx_stall;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_stall = 0;
        end
        else if (rx_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_stall--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (m_axis_tvalid)
                rx_stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
        end
    end

    // Monitor: compare each closed bar with the oldest prediction
    always @(posedge clk)
    begin
        bar_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = bar_t'(m_axis_tdata[208:0]);
            bars_seen++;
            if (expected_bars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected bar minute=%0d", got.minute);
            end
            else
            begin
                want = expected_bars[0];
                expected_bars.delete(0);
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: bar %0d mismatch", bars_seen);
                        $display("  exp min=%0d o=%0d h=%0d l=%0d c=%0d v=%0d avg=%0d n=%0d",
                                 want.minute, $signed(want.open_px), $signed(want.high_px),
                                 $signed(want.low_px), $signed(want.close_px), want.volume,
                                 want.avg, want.count);
                        $display("  got min=%0d o=%0d h=%0d l=%0d c=%0d v=%0d avg=%0d n=%0d",
                                 got.minute, $signed(got.open_px), $signed(got.high_px),
                                 $signed(got.low_px), $signed(got.close_px), got.volume,
                                 got.avg, got.count);
                    end
                end
            end
        end
    end

    // Watchdog
    longint cycles;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("minute_bar_atr_builder verification failed");
            $finish;
        end
    end

    function automatic tick_t make_tick(logic [10:0] m, logic [31:0] p, logic [31:0] v);
        tick_t t;
        t.minute = m;
        t.price = p;
        t.volume = v;
        return t;
    endfunction

    // Append one tick to the driver queue
    function automatic void queue_tick(tick_t t);
        pending_ticks.insert(pending_ticks.size(), t);
    endfunction

    function automatic logic [31:0] rand_price(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'(100000 + $urandom_range(0, 2000) - 1000);
            default: return 32'(-$urandom_range(0, 500));
        endcase
    endfunction

    // Wait until the block is idle, then write the window register
    task automatic set_window(logic [6:0] w);
        while (pending_ticks.size() > 0 || s_axis_tvalid || expected_bars.size() > 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= w;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        win_len = w;
        config_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Queue a phase of random ticks: mostly realistic minute runs, some noise
    task automatic queue_phase(int n);
        logic [10:0] m;
        int mode, run;
        m = 11'($urandom_range(0, 1439));
        mode = $urandom_range(0, 2);
        while (n > 0)
        begin
            if ($urandom_range(0, 9) == 0)
                m = 11'($urandom_range(0, 2047));
            else
                m = (m == 1439) ? 11'd0 : m + 11'd1;
            run = $urandom_range(1, 4);
            for (int k = 0; k < run && n > 0; k++, n--)
                queue_tick(make_tick(m, rand_price(mode),
                    ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 1000)));
        end
        while (pending_ticks.size() > 0) @(posedge clk);
    endtask

    initial
    begin
        logic [6:0] windows[8];
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        win_len = mbab_pkg::WINDOW_RESET;
        bar_open_flag = 0;
        run_minute = 0;
        cur_open = 0; cur_high = 0; cur_low = 0; cur_close = 0; cur_volume = 0;
        hist_fill = 0;
        hist_head = 0;
        ticks_sent = 0; bars_seen = 0; mismatches = 0; config_writes = 0;
        cycles = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: first tick opens, same-minute merge, extremes, volume overflow
        queue_tick(make_tick(11'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        queue_tick(make_tick(11'd0, 32'h8000_0000, 32'hFFFF_FFFF));
        queue_tick(make_tick(11'd0, 32'd5, 32'd0));
        queue_tick(make_tick(11'd1439, 32'h8000_0000, 32'd1));
        queue_tick(make_tick(11'd2047, 32'h7FFF_FFFF, 32'd2));
        queue_tick(make_tick(11'd2047, 32'h8000_0000, 32'h5555_5555));
        queue_tick(make_tick(11'd1, 32'hFFFF_FFFF, 32'hAAAA_AAAA));
        queue_tick(make_tick(11'd1, 32'h0000_0000, 32'hFFFF_FFFF));
        queue_tick(make_tick(11'h555, 32'h5555_5555, 32'h0));
        queue_tick(make_tick(11'h2AA, 32'hAAAA_AAAA, 32'h1));
        queue_tick(make_tick(11'd3, 32'h7FFF_FFFF, 32'd7));
        queue_tick(make_tick(11'd4, 32'h8000_0000, 32'd7));
        queue_tick(make_tick(11'd5, 32'd100, 32'd7));
        while (pending_ticks.size() > 0) @(posedge clk);

        // Random phases across window settings, extremes and out-of-range values
        windows = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd65, 7'd2, 7'd40};
        foreach (windows[i])
        begin
            set_window(windows[i]);
            queue_phase(230);
        end
        set_window(7'd64);
        queue_phase(120);
        set_window(7'd4);
        queue_phase(60);

        // Drain and settle
        while (s_axis_tvalid || expected_bars.size() > 0) @(posedge clk);
        repeat (150) @(posedge clk);

        $display("Sent %0d ticks over %0d window settings; %0d closed bars checked.",
                 ticks_sent, config_writes, bars_seen);
        if (mismatches == 0 && expected_bars.size() == 0)
            $display("minute_bar_atr_builder verification clean");
        else
        begin
            $display("%0d mismatches, %0d bars missing", mismatches, expected_bars.size());
            $display("minute_bar_atr_builder verification failed");
        end
        $finish;
    end

endmodule
